// File: rtl/core/ebml_pkg.sv
// Shared types, constants and encoding functions for the EBML element serializer.
// No dependencies; every other file in rtl/core refers to it by scoped names.
`default_nettype none

package ebml_pkg;

    // Request operations
    typedef enum logic [1:0] {
        OP_UINT   = 2'd0,
        OP_HEADER = 2'd1,
        OP_FLOAT  = 2'd2,
        OP_BLOCK  = 2'd3
    } op_t;

    localparam int MAX_TRACKS_DEFAULT = 64;
    localparam int NUM_SEGS           = 4;
    localparam int PLAN_DEPTH         = 2;

    localparam logic [7:0]  BLOCK_ID      = 8'hA3;
    localparam logic [7:0]  FLOAT_SIZE    = 8'h84;
    localparam logic [7:0]  VINT1_MARK    = 8'h80;
    localparam logic [31:0] BLOCK_SIZE_MAX = 32'hFFFF_FFFB;
    localparam logic [31:0] BLOCK_HDR_LEN = 32'd4;

    // One run of bytes, sent from byte len-1 down to byte 0 of data
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  len;
    } seg_t;

    // Classified request: ID, size vint, track vint, tail bytes
    typedef struct packed {
        seg_t [NUM_SEGS-1:0] seg;
        logic                err;
    } plan_t;

    localparam logic [1:0] SEG_ID    = 2'd0;
    localparam logic [1:0] SEG_SIZE  = 2'd1;
    localparam logic [1:0] SEG_TRACK = 2'd2;
    localparam logic [1:0] SEG_TAIL  = 2'd3;

    // Element ID with leading zero bytes trimmed (zero ID is one 0x00 byte)
    function automatic seg_t id_enc(input logic [31:0] id);
        seg_t s;
        s.data = {32'd0, id};
        if (id[31:24] != 8'd0)
        begin
            s.len = 4'd4;
        end
        else if (id[23:16] != 8'd0)
        begin
            s.len = 4'd3;
        end
        else if (id[15:8] != 8'd0)
        begin
            s.len = 4'd2;
        end
        else
        begin
            s.len = 4'd1;
        end
        return s;
    endfunction

    // Size vint: shortest class whose all-ones value stays above v
    function automatic seg_t vint_enc(input logic [31:0] v);
        seg_t s;
        if (v < 32'h0000_007F)
        begin
            s.data = {56'd0, VINT1_MARK | v[7:0]};
            s.len  = 4'd1;
        end
        else if (v < 32'h0000_3FFF)
        begin
            s.data = {48'd0, 16'h4000 | v[15:0]};
            s.len  = 4'd2;
        end
        else if (v < 32'h001F_FFFF)
        begin
            s.data = {40'd0, 24'h20_0000 | v[23:0]};
            s.len  = 4'd3;
        end
        else if (v < 32'h0FFF_FFFF)
        begin
            s.data = {32'd0, 32'h1000_0000 | v};
            s.len  = 4'd4;
        end
        else
        begin
            s.data = {24'd0, 8'h08, v};
            s.len  = 4'd5;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ebml_front.sv
// Front end: num_tracks register and request classification into a byte plan.
// Depends on ebml_pkg.
`default_nettype none

module ebml_front #(
    parameter int MAX_TRACKS = ebml_pkg::MAX_TRACKS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [5:0]         cfg_wdata,
    input  wire logic [1:0]         op,
    input  wire logic [31:0]        elem_id,
    input  wire logic [31:0]        elem_size,
    input  wire logic [63:0]        value,
    input  wire logic [7:0]         track,
    input  wire logic signed [15:0] block_delta,
    input  wire logic               key_frame,
    input  wire logic               skippable_flag,
    output ebml_pkg::plan_t         plan
);

    localparam logic [8:0] TRACK_LIMIT = 9'(MAX_TRACKS);

    logic [5:0]      num_tracks_reg;
    logic [3:0]      vlen;
    logic            bad_block;
    ebml_pkg::seg_t  id_seg;

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_tracks_reg <= 6'd1;
        end
        else if (cfg_we)
        begin
            num_tracks_reg <= cfg_wdata;
        end
    end

    // Minimal byte count of the uint value
    always_comb
    begin
        vlen = 4'd1;
        for (int k = 1; k < 8; k++)
        begin
            if (value[8*k +: 8] != 8'd0)
            begin
                vlen = 4'(k + 1);
            end
        end
    end

    assign id_seg = ebml_pkg::id_enc(elem_id);

    // Block request checks: track range and size overflow
    assign bad_block = (track == 8'd0) || (track > {2'd0, num_tracks_reg}) ||
                       ({1'b0, track} >= TRACK_LIMIT) ||
                       (elem_size > ebml_pkg::BLOCK_SIZE_MAX);

    // Classify
    always_comb
    begin
        plan = '0;
        unique case (ebml_pkg::op_t'(op))
            ebml_pkg::OP_UINT:
            begin
                plan.seg[ebml_pkg::SEG_ID]        = id_seg;
                plan.seg[ebml_pkg::SEG_SIZE].data = {56'd0, ebml_pkg::VINT1_MARK | {4'd0, vlen}};
                plan.seg[ebml_pkg::SEG_SIZE].len  = 4'd1;
                plan.seg[ebml_pkg::SEG_TAIL].data = value;
                plan.seg[ebml_pkg::SEG_TAIL].len  = vlen;
            end
            ebml_pkg::OP_HEADER:
            begin
                plan.seg[ebml_pkg::SEG_ID]   = id_seg;
                plan.seg[ebml_pkg::SEG_SIZE] = ebml_pkg::vint_enc(elem_size);
            end
            ebml_pkg::OP_FLOAT:
            begin
                plan.seg[ebml_pkg::SEG_ID]        = id_seg;
                plan.seg[ebml_pkg::SEG_SIZE].data = {56'd0, ebml_pkg::FLOAT_SIZE};
                plan.seg[ebml_pkg::SEG_SIZE].len  = 4'd1;
                plan.seg[ebml_pkg::SEG_TAIL].data = {32'd0, value[31:0]};
                plan.seg[ebml_pkg::SEG_TAIL].len  = 4'd4;
            end
            ebml_pkg::OP_BLOCK:
            begin
                if (bad_block)
                begin
                    // single zero byte flagged as error
                    plan.seg[ebml_pkg::SEG_ID].len = 4'd1;
                    plan.err                       = 1'b1;
                end
                else
                begin
                    plan.seg[ebml_pkg::SEG_ID].data  = {56'd0, ebml_pkg::BLOCK_ID};
                    plan.seg[ebml_pkg::SEG_ID].len   = 4'd1;
                    plan.seg[ebml_pkg::SEG_SIZE]     =
                        ebml_pkg::vint_enc(32'(elem_size + ebml_pkg::BLOCK_HDR_LEN));
                    plan.seg[ebml_pkg::SEG_TRACK]    = ebml_pkg::vint_enc({24'd0, track});
                    plan.seg[ebml_pkg::SEG_TAIL].data =
                        {40'd0, block_delta, key_frame, 6'd0, skippable_flag};
                    plan.seg[ebml_pkg::SEG_TAIL].len = 4'd3;
                end
            end
            default:
            begin
                plan = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/ebml_plan_q.sv
// Short queue of classified plans between front end and serializer.
// Depends on ebml_pkg.
`default_nettype none

module ebml_plan_q (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire ebml_pkg::plan_t  wr_plan,
    output logic                  q_full,
    output logic                  q_empty,
    input  wire logic             rd_en,
    output ebml_pkg::plan_t       rd_plan
);

    localparam int DEPTH = ebml_pkg::PLAN_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ebml_pkg::plan_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                do_wr;
    logic                do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_plan = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_plan;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= CNT_W'(count_reg - 1'b1);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ebml_back.sv
// Back end: walks the head plan segment by segment, one byte per cycle while the
// output register is empty or being popped, into an output register. Depends on ebml_pkg.
`default_nettype none

module ebml_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             plan_valid,
    input  wire ebml_pkg::plan_t  plan,
    output logic                  plan_done,
    output logic                  empty,
    input  wire logic             pop,
    output logic [7:0]            out_byte,
    output logic                  last,
    output logic                  error
);

    logic [1:0]      seg_reg;
    logic [1:0]      seg_next;
    logic [2:0]      pos_reg;
    logic [2:0]      pos_next;
    logic            ov_reg;
    logic [7:0]      ob_reg;
    logic            ol_reg;
    logic            oe_reg;

    ebml_pkg::seg_t  cur;
    logic [2:0]      idx;
    logic            seg_end;
    logic            have_next;
    logic [1:0]      nxt_seg;
    logic            emit;
    logic            is_last;

    assign cur     = plan.seg[seg_reg];
    assign idx     = 3'(cur.len - 4'd1 - {1'b0, pos_reg});
    assign seg_end = ({1'b0, pos_reg} == 4'(cur.len - 4'd1));
    assign emit    = plan_valid && (!ov_reg || pop);

    // Next non-empty segment after the current one
    always_comb
    begin
        have_next = 1'b0;
        nxt_seg   = seg_reg;
        for (int s = ebml_pkg::NUM_SEGS - 1; s > 0; s--)
        begin
            if ((2'(s) > seg_reg) && (plan.seg[s].len != 4'd0))
            begin
                have_next = 1'b1;
                nxt_seg   = 2'(s);
            end
        end
    end

    assign is_last   = seg_end && !have_next;
    assign plan_done = emit && is_last;

    // Cursor update
    always_comb
    begin
        seg_next = seg_reg;
        pos_next = pos_reg;
        if (emit)
        begin
            if (is_last)
            begin
                seg_next = ebml_pkg::SEG_ID;
                pos_next = 3'd0;
            end
            else if (seg_end)
            begin
                seg_next = nxt_seg;
                pos_next = 3'd0;
            end
            else
            begin
                pos_next = 3'(pos_reg + 3'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg <= ebml_pkg::SEG_ID;
            pos_reg <= 3'd0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            seg_reg <= seg_next;
            pos_reg <= pos_next;
            ov_reg  <= emit || (ov_reg && !pop);
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ob_reg <= cur.data[8*idx +: 8];
            ol_reg <= is_last;
            oe_reg <= plan.err;
        end
    end

    assign empty    = !ov_reg;
    assign out_byte = ob_reg;
    assign last     = ol_reg;
    assign error    = oe_reg;

endmodule

`default_nettype wire

// File: rtl/core/ebml_element_serializer.sv
// EBML element serializer: a request comes in on a push/full queue port, and
// its encoded bytes leave on an empty/pop queue port, one per cycle while pop
// is held, last marking the final byte and error marking a rejected block
// request (a single zero byte). A request has 1 to 13 bytes. A new request
// is accepted every cycle while the 2-entry plan queue has room, so
// classification overlaps output. The declared track count is written
// through cfg_we/cfg_wdata; the user must write it only while the block is
// idle, which the block itself does not enforce.
// Depends on ebml_pkg, ebml_front, ebml_plan_q and ebml_back.
`default_nettype none

module ebml_element_serializer #(
    parameter int MAX_TRACKS = ebml_pkg::MAX_TRACKS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [5:0]         cfg_wdata,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         op,
    input  wire logic [31:0]        elem_id,
    input  wire logic [31:0]        elem_size,
    input  wire logic [63:0]        value,
    input  wire logic [7:0]         track,
    input  wire logic signed [15:0] block_delta,
    input  wire logic               key_frame,
    input  wire logic               skippable_flag,
    output logic                    empty,
    input  wire logic               pop,
    output logic [7:0]              out_byte,
    output logic                    last,
    output logic                    error
);

    ebml_pkg::plan_t front_plan;
    ebml_pkg::plan_t head_plan;
    logic            q_empty;
    logic            plan_done;

    // Classification
    ebml_front #(
        .MAX_TRACKS (MAX_TRACKS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .op             (op),
        .elem_id        (elem_id),
        .elem_size      (elem_size),
        .value          (value),
        .track          (track),
        .block_delta    (block_delta),
        .key_frame      (key_frame),
        .skippable_flag (skippable_flag),
        .plan           (front_plan)
    );

    // Plan queue
    ebml_plan_q u_plan_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_plan (front_plan),
        .q_full  (full),
        .q_empty (q_empty),
        .rd_en   (plan_done),
        .rd_plan (head_plan)
    );

    // Byte serializer
    ebml_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .plan_valid (!q_empty),
        .plan       (head_plan),
        .plan_done  (plan_done),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .last       (last),
        .error      (error)
    );

endmodule

`default_nettype wire

// File: verif/ebml_checker.sv
// Scoreboard for the EBML element serializer: watches the request and byte queues,
// predicts the byte stream of every accepted request and compares it on the way out.
// Depends on ebml_pkg for the operation codes and block constants.
`timescale 1ns / 1ps

module ebml_checker #(
    parameter int MAX_TRACKS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [5:0]         cfg_wdata,
    input  logic               push,
    input  logic               full,
    input  logic [1:0]         op,
    input  logic [31:0]        elem_id,
    input  logic [31:0]        elem_size,
    input  logic [63:0]        value,
    input  logic [7:0]         track,
    input  logic signed [15:0] block_delta,
    input  logic               key_frame,
    input  logic               skippable_flag,
    input  logic               empty,
    input  logic               pop,
    input  logic [7:0]         out_byte,
    input  logic               last,
    input  logic               error,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } enc_byte_t;

    enc_byte_t  expected_bytes[$];
    logic [5:0] track_limit;

    function automatic void queue_byte(input logic [7:0] b);
        enc_byte_t e;
        e.data = b;
        e.last = 1'b0;
        e.err  = 1'b0;
        expected_bytes.push_back(e);
    endfunction

    // ID big-endian, leading zero bytes dropped, at least one byte
    function automatic void queue_id(input logic [31:0] id);
        int k;
        k = 3;
        while (k > 0 && id[8*k +: 8] == 8'd0)
            k--;
        for (; k >= 0; k--)
            queue_byte(id[8*k +: 8]);
    endfunction

    // Size vint in the shortest class that stays below its all-ones value
    function automatic void queue_vint(input logic [31:0] v);
        if (v < 32'h0000_007F)
        begin
            queue_byte(8'h80 | v[7:0]);
        end
        else if (v < 32'h0000_3FFF)
        begin
            queue_byte(8'h40 | v[15:8]);
            queue_byte(v[7:0]);
        end
        else if (v < 32'h001F_FFFF)
        begin
            queue_byte(8'h20 | v[23:16]);
            queue_byte(v[15:8]);
            queue_byte(v[7:0]);
        end
        else if (v < 32'h0FFF_FFFF)
        begin
            queue_byte(8'h10 | v[31:24]);
            queue_byte(v[23:16]);
            queue_byte(v[15:8]);
            queue_byte(v[7:0]);
        end
        else
        begin
            queue_byte(8'h08);
            queue_byte(v[31:24]);
            queue_byte(v[23:16]);
            queue_byte(v[15:8]);
            queue_byte(v[7:0]);
        end
    endfunction

    // Expected byte stream of the request on the input ports
    function automatic void predict_encoding();
        int        len;
        int        k;
        enc_byte_t rej;
        case (ebml_pkg::op_t'(op))
            ebml_pkg::OP_UINT:
            begin
                len = 8;
                while (len > 1 && value[8*(len-1) +: 8] == 8'd0)
                    len--;
                queue_id(elem_id);
                queue_vint(32'(len));
                for (k = len - 1; k >= 0; k--)
                    queue_byte(value[8*k +: 8]);
            end
            ebml_pkg::OP_HEADER:
            begin
                queue_id(elem_id);
                queue_vint(elem_size);
            end
            ebml_pkg::OP_FLOAT:
            begin
                queue_id(elem_id);
                queue_vint(32'd4);
                for (k = 3; k >= 0; k--)
                    queue_byte(value[8*k +: 8]);
            end
            default:
            begin
                if (track == 8'd0 || track > {2'b00, track_limit} ||
                    int'(track) >= MAX_TRACKS || elem_size > ebml_pkg::BLOCK_SIZE_MAX)
                begin
                    // rejected block: one zero byte flagged as error
                    rej.data = 8'd0;
                    rej.last = 1'b1;
                    rej.err  = 1'b1;
                    expected_bytes.push_back(rej);
                    return;
                end
                queue_id({24'd0, ebml_pkg::BLOCK_ID});
                queue_vint(elem_size + 32'd4);
                queue_vint({24'd0, track});
                queue_byte(block_delta[15:8]);
                queue_byte(block_delta[7:0]);
                queue_byte({key_frame, 6'd0, skippable_flag});
            end
        endcase
        expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_limit = 6'd1;
            expected_bytes.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            // outgoing byte against the oldest expectation
            if (pop && !empty)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected output byte %0h (last %0b error %0b)",
                           out_byte, last, error);
                    errors++;
                end
                else
                begin
                    enc_byte_t e;
                    e = expected_bytes.pop_front();
                    if (out_byte !== e.data)
                    begin
                        $error("out_byte: expected %0h, actual %0h", e.data, out_byte);
                        errors++;
                    end
                    if (last !== e.last)
                    begin
                        $error("last: expected %0b, actual %0b", e.last, last);
                        errors++;
                    end
                    if (error !== e.err)
                    begin
                        $error("error: expected %0b, actual %0b", e.err, error);
                        errors++;
                    end
                end
            end
            // accepted request
            if (push && !full)
                predict_encoding();
            if (cfg_we)
                track_limit = cfg_wdata;
            pending = expected_bytes.size();
        end
    end

endmodule

// File: verif/tb_top.sv
// Testbench top for the EBML element serializer: clock, reset, request and pop
// stimulus with random idling, num_tracks phases and the final verdict.
// Depends on ebml_pkg, the serializer RTL and ebml_checker.
`timescale 1ns / 1ps

module tb_top;

    import ebml_pkg::*;

    typedef struct {
        op_t               op;
        logic [31:0]       id;
        logic [31:0]       size;
        logic [63:0]       val;
        logic [7:0]        trk;
        logic signed [15:0] delta;
        logic              key;
        logic              skip;
    } elem_req_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [5:0]         cfg_wdata;
    logic               push;
    logic               full;
    logic [1:0]         op;
    logic [31:0]        elem_id;
    logic [31:0]        elem_size;
    logic [63:0]        value;
    logic [7:0]         track;
    logic signed [15:0] block_delta;
    logic               key_frame;
    logic               skippable_flag;
    logic               empty;
    logic               pop;
    logic [7:0]         out_byte;
    logic               last;
    logic               error;

    int                 fail_count;
    int                 pending;
    logic               quiet;
    logic               long_hold_req;
    logic [5:0]         cur_tc;

    ebml_element_serializer DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .push           (push),
        .full           (full),
        .op             (op),
        .elem_id        (elem_id),
        .elem_size      (elem_size),
        .value          (value),
        .track          (track),
        .block_delta    (block_delta),
        .key_frame      (key_frame),
        .skippable_flag (skippable_flag),
        .empty          (empty),
        .pop            (pop),
        .out_byte       (out_byte),
        .last           (last),
        .error          (error)
    );

    ebml_checker #(.MAX_TRACKS(64)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .push           (push),
        .full           (full),
        .op             (op),
        .elem_id        (elem_id),
        .elem_size      (elem_size),
        .value          (value),
        .track          (track),
        .block_delta    (block_delta),
        .key_frame      (key_frame),
        .skippable_flag (skippable_flag),
        .empty          (empty),
        .pop            (pop),
        .out_byte       (out_byte),
        .last           (last),
        .error          (error),
        .errors         (fail_count),
        .pending        (pending)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic elem_req_t make_req(input op_t o, input logic [31:0] id,
                                           input logic [31:0] sz, input logic [63:0] v,
                                           input logic [7:0] t, input logic [15:0] d,
                                           input logic k, input logic s);
        elem_req_t r;
        r.op    = o;
        r.id    = id;
        r.size  = sz;
        r.val   = v;
        r.trk   = t;
        r.delta = d;
        r.key   = k;
        r.skip  = s;
        return r;
    endfunction

    // Random value of at most nbytes significant bytes (0 gives zero)
    function automatic logic [63:0] rnd_wide(input int nbytes);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (nbytes == 0)
            return 64'd0;
        return v >> (64 - 8 * nbytes);
    endfunction

    // Size with a bias toward vint class boundaries
    function automatic logic [31:0] pick_size();
        logic [31:0] edges[14];
        edges = '{32'h7A, 32'h7B, 32'h7E, 32'h7F, 32'h3FFB, 32'h3FFE, 32'h3FFF,
                  32'h1FFFFE, 32'h1FFFFF, 32'h0FFFFFFE, 32'h0FFFFFFF,
                  32'hFFFFFFFB, 32'hFFFFFFFF, 32'h0};
        case ($urandom_range(0, 5))
            0, 1, 2, 3: return 32'(rnd_wide($urandom_range(1, 4)));
            4:          return edges[$urandom_range(0, 13)];
            default:    return $urandom;
        endcase
    endfunction

    function automatic elem_req_t rand_request();
        elem_req_t r;
        r.op    = op_t'($urandom_range(0, 3));
        r.id    = 32'(rnd_wide($urandom_range(0, 4)));
        r.size  = pick_size();
        r.val   = rnd_wide($urandom_range(0, 8));
        r.delta = 16'($urandom);
        r.key   = 1'($urandom);
        r.skip  = 1'($urandom);
        r.trk   = 8'($urandom);
        if (r.op == OP_BLOCK)
        begin
            // mostly well-formed blocks, some bad tracks and oversize frames
            if ($urandom_range(0, 99) < 85)
            begin
                r.trk = 8'($urandom_range(1, cur_tc));
                if (r.size > BLOCK_SIZE_MAX)
                    r.size = BLOCK_SIZE_MAX;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       r.trk = 8'd0;
                    1:       r.trk = 8'($urandom_range(cur_tc + 1, 255));
                    default: r.size = $urandom_range(32'hFFFFFFFC, 32'hFFFFFFFF);
                endcase
                if (r.trk == 8'd0 || r.trk > cur_tc || r.size > BLOCK_SIZE_MAX)
                    r.trk = r.trk;
                else
                    r.trk = 8'd0;
            end
        end
        return r;
    endfunction

    // Offer one request, idling first at random, and wait for acceptance
    task automatic offer_request(input elem_req_t r);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        op             = r.op;
        elem_id        = r.id;
        elem_size      = r.size;
        value          = r.val;
        track          = r.trk;
        block_delta    = r.delta;
        key_frame      = r.key;
        skippable_flag = r.skip;
        push           = 1'b1;
        do
            @(posedge clk);
        while (full);
    endtask

    // Drop push and wait until every expected byte has been popped
    task automatic drain();
        @(negedge clk);
        push = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Write num_tracks while the block is idle
    task automatic write_num_tracks(input logic [5:0] tc);
        drain();
        repeat (4) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = tc;
        cur_tc    = tc;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Receiver: random pop stalls plus one long hold-off on request
    initial
    begin
        int stall;
        int hold;
        stall = 0;
        hold  = 0;
        pop   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold = 300;
            end
            if (hold > 0)
            begin
                pop = 1'b0;
                hold--;
            end
            else if (stall > 0)
            begin
                pop = 1'b0;
                stall--;
            end
            else if (!quiet && rst_n && $urandom_range(0, 5) == 0)
            begin
                pop   = 1'b0;
                stall = $urandom_range(1, 12) - 1;
            end
            else
            begin
                pop = 1'b1;
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [5:0] phase_tc[5];
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 6'd0;
        push           = 1'b0;
        op             = 2'd0;
        elem_id        = 32'd0;
        elem_size      = 32'd0;
        value          = 64'd0;
        track          = 8'd0;
        block_delta    = 16'sd0;
        key_frame      = 1'b0;
        skippable_flag = 1'b0;
        quiet          = 1'b0;
        long_hold_req  = 1'b0;
        cur_tc         = 6'd1;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed: ID and value extremes, every vint class edge, float, blocks
        offer_request(make_req(OP_UINT, 32'h0, 32'h0, 64'h0, 8'd0, 16'h0, 1'b0, 1'b0));
        offer_request(make_req(OP_UINT, 32'hFFFFFFFF, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
                               8'hFF, 16'hFFFF, 1'b1, 1'b1));
        offer_request(make_req(OP_UINT, 32'h4286, 32'h0, 64'h80, 8'd0, 16'h0, 1'b0, 1'b0));
        offer_request(make_req(OP_UINT, 32'h1A45DFA3, 32'h0, 64'h0100000000000000,
                               8'd0, 16'h0, 1'b0, 1'b0));
        offer_request(make_req(OP_HEADER, 32'h18538067, 32'h0, 64'h0, 8'd0, 16'h0,
                               1'b0, 1'b0));
        offer_request(make_req(OP_HEADER, 32'h1F43B6, 32'h7E, 64'h0, 8'd0, 16'h0, 1'b0, 1'b0));
        offer_request(make_req(OP_HEADER, 32'h1F43B6, 32'h7F, 64'h0, 8'd0, 16'h0, 1'b0, 1'b0));
        offer_request(make_req(OP_HEADER, 32'hE7, 32'h3FFE, 64'h0, 8'd0, 16'h0, 1'b0, 1'b0));
        offer_request(make_req(OP_HEADER, 32'hE7, 32'h3FFF, 64'h0, 8'd0, 16'h0, 1'b0, 1'b0));
        offer_request(make_req(OP_HEADER, 32'hA0, 32'h1FFFFE, 64'h0, 8'd0, 16'h0, 1'b0, 1'b0));
        offer_request(make_req(OP_HEADER, 32'hA0, 32'h1FFFFF, 64'h0, 8'd0, 16'h0, 1'b0, 1'b0));
        offer_request(make_req(OP_HEADER, 32'h0, 32'h0FFFFFFE, 64'h0, 8'd0, 16'h0, 1'b0, 1'b0));
        offer_request(make_req(OP_HEADER, 32'h0, 32'h0FFFFFFF, 64'h0, 8'd0, 16'h0, 1'b0, 1'b0));
        offer_request(make_req(OP_HEADER, 32'h0, 32'hFFFFFFFF, 64'h0, 8'd0, 16'h0, 1'b0, 1'b0));
        offer_request(make_req(OP_FLOAT, 32'h4489, 32'h0, 64'hDEADBEEF3F800000, 8'd0, 16'h0,
                               1'b0, 1'b0));
        // num_tracks still at its reset value of 1
        offer_request(make_req(OP_BLOCK, 32'h0, 32'h0, 64'h0, 8'd1, 16'h8000, 1'b1, 1'b1));
        offer_request(make_req(OP_BLOCK, 32'h0, 32'h10, 64'h0, 8'd0, 16'h0, 1'b0, 1'b0));
        offer_request(make_req(OP_BLOCK, 32'h0, 32'h10, 64'h0, 8'd2, 16'h0, 1'b0, 1'b0));
        offer_request(make_req(OP_BLOCK, 32'h0, 32'hFFFFFFFC, 64'h0, 8'd1, 16'h0, 1'b0, 1'b0));
        offer_request(make_req(OP_BLOCK, 32'h0, 32'hFFFFFFFB, 64'h0, 8'd1, 16'h7FFF,
                               1'b0, 1'b1));
        write_num_tracks(6'd63);
        offer_request(make_req(OP_BLOCK, 32'h0, 32'h7B, 64'h0, 8'd63, 16'hFFFF, 1'b1, 1'b0));
        offer_request(make_req(OP_BLOCK, 32'h0, 32'h7A, 64'h0, 8'd64, 16'h0, 1'b0, 1'b0));
        offer_request(make_req(OP_BLOCK, 32'h0, 32'h7A, 64'h0, 8'd255, 16'h0, 1'b0, 1'b0));

        // Random phases over several num_tracks settings
        phase_tc[0] = 6'd63;
        phase_tc[1] = 6'd1;
        phase_tc[2] = 6'($urandom_range(2, 62));
        phase_tc[3] = 6'd32;
        phase_tc[4] = 6'($urandom_range(1, 63));
        for (int p = 0; p < 5; p++)
        begin
            write_num_tracks(phase_tc[p]);
            for (int i = 0; i < 62; i++)
            begin
                if (p == 1 && i == 5)
                    long_hold_req = 1'b1;
                if (p == 4 && i >= 20)
                    quiet = 1'b1;
                offer_request(rand_request());
            end
        end

        drain();
        repeat (30) @(negedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/ebml_pkg.sv
rtl/core/ebml_front.sv
rtl/core/ebml_plan_q.sv
rtl/core/ebml_back.sv
rtl/core/ebml_element_serializer.sv
verif/ebml_checker.sv
verif/tb_top.sv
